[hw/rtl/line_sensor_proportional_steering_defines.svh]
// assertion macros for the steering block checker
`ifndef LINE_SENSOR_PROPORTIONAL_STEERING_DEFINES_SVH
`define LINE_SENSOR_PROPORTIONAL_STEERING_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LSPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsps check failed");

// next-cycle implication, quiet during reset
`define LSPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsps check failed");

`endif

[hw/rtl/lsps_pkg.sv]
// shared types and constants of the line sensor steering block
package lsps_pkg;

   localparam int CONV_W    = 8;
   localparam int THRESH_W  = 10;
   localparam int GAIN_W    = 16;
   localparam int COMPARE_W = 16;
   localparam int FRONT_W   = 10;
   localparam int CHAN_W    = 2;
   localparam int FRAC_BITS = 8;

   // csr bus
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_LINE_THRESHOLD = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_STEER_GAIN     = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_BASE_COMPARE   = 2'd2;

   localparam logic [THRESH_W-1:0]  THRESHOLD_RESET = 10'd512;
   localparam logic [GAIN_W-1:0]    GAIN_RESET      = 16'd384;
   localparam logic [COMPARE_W-1:0] BASE_RESET      = 16'd12499;

   // scan channels
   localparam logic [CHAN_W-1:0] CH_LEFT   = 2'd0;
   localparam logic [CHAN_W-1:0] CH_MIDDLE = 2'd1;
   localparam logic [CHAN_W-1:0] CH_RIGHT  = 2'd2;
   localparam logic [CHAN_W-1:0] CH_FRONT  = 2'd3;

   typedef struct packed {
      logic [THRESH_W-1:0]  line_threshold;
      logic [GAIN_W-1:0]    steer_gain;
      logic [COMPARE_W-1:0] base_compare;
   } csr_regs_type;

   typedef struct packed {
      logic [COMPARE_W-1:0] compare_a;
      logic [COMPARE_W-1:0] compare_b;
      logic                 steering_on;
   } steer_result_type;

endpackage

[hw/rtl/lsps_csr.sv]
// apb-style register file for threshold, gain and base compare
module lsps_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lsps_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [lsps_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [lsps_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output lsps_pkg::csr_regs_type               regs
);

   lsps_pkg::csr_regs_type regs_ff;
   lsps_pkg::csr_regs_type regs_in;
   logic [lsps_pkg::REG_IDX_W-1:0] reg_idx;
   logic                            wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[lsps_pkg::CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (reg_idx)
            lsps_pkg::REG_LINE_THRESHOLD:
               regs_in.line_threshold = pwdata[lsps_pkg::THRESH_W-1:0];
            lsps_pkg::REG_STEER_GAIN:
               regs_in.steer_gain = pwdata[lsps_pkg::GAIN_W-1:0];
            lsps_pkg::REG_BASE_COMPARE:
               regs_in.base_compare = pwdata[lsps_pkg::COMPARE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.line_threshold <= lsps_pkg::THRESHOLD_RESET;
         regs_ff.steer_gain     <= lsps_pkg::GAIN_RESET;
         regs_ff.base_compare   <= lsps_pkg::BASE_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         lsps_pkg::REG_LINE_THRESHOLD:
            prdata = lsps_pkg::CSR_DATA_W'(regs_ff.line_threshold);
         lsps_pkg::REG_STEER_GAIN:
            prdata = lsps_pkg::CSR_DATA_W'(regs_ff.steer_gain);
         lsps_pkg::REG_BASE_COMPARE:
            prdata = lsps_pkg::CSR_DATA_W'(regs_ff.base_compare);
         default:
            prdata = '0;
      endcase
   end

   assign regs = regs_ff;

endmodule

[hw/rtl/lsps_steer.sv]
// proportional steering: line detect, imbalance, scaled and saturated reduction
module lsps_steer #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic [SAMPLE_BITS-1:0]      left_level,
   input  logic [SAMPLE_BITS-1:0]      middle_level,
   input  logic [SAMPLE_BITS-1:0]      right_level,
   input  lsps_pkg::csr_regs_type      regs,
   output lsps_pkg::steer_result_type  result
);

   localparam int CMP_W  = (SAMPLE_BITS > lsps_pkg::THRESH_W) ? SAMPLE_BITS
                                                              : lsps_pkg::THRESH_W;
   localparam int PROD_W = lsps_pkg::GAIN_W + SAMPLE_BITS;
   localparam int SUM_W  = PROD_W + 1;
   localparam int RED_W  = SUM_W - lsps_pkg::FRAC_BITS;
   localparam logic [SUM_W-1:0] ROUND_UP = SUM_W'((1 << lsps_pkg::FRAC_BITS) - 1);

   logic [CMP_W-1:0]                 thresh_x;
   logic                             line_seen;
   logic                             left_lt_right;
   logic [SAMPLE_BITS-1:0]           diff;
   logic [PROD_W-1:0]                prod;
   logic [SUM_W-1:0]                 rounded;
   logic [RED_W-1:0]                 reduction;
   logic [lsps_pkg::COMPARE_W-1:0]   lowered;
   logic [lsps_pkg::COMPARE_W-1:0]   base;

   assign base     = regs.base_compare;
   assign thresh_x = CMP_W'(regs.line_threshold);

   assign line_seen = (CMP_W'(left_level) > thresh_x)   ||
                      (CMP_W'(middle_level) > thresh_x) ||
                      (CMP_W'(right_level) > thresh_x);

   assign left_lt_right = left_level < right_level;
   assign diff          = left_lt_right ? (right_level - left_level)
                                        : (left_level - right_level);

   // gain is q8.8, round the reduction up
   assign prod      = PROD_W'(regs.steer_gain) * PROD_W'(diff);
   assign rounded   = SUM_W'(prod) + ROUND_UP;
   assign reduction = rounded[SUM_W-1:lsps_pkg::FRAC_BITS];

   // clamp at zero instead of wrapping
   assign lowered = (reduction >= RED_W'(base))
                    ? '0
                    : base - reduction[lsps_pkg::COMPARE_W-1:0];

   assign result.compare_a   = (line_seen && left_lt_right)  ? lowered : base;
   assign result.compare_b   = (line_seen && !left_lt_right) ? lowered : base;
   assign result.steering_on = line_seen;

endmodule

[hw/rtl/line_sensor_proportional_steering.sv]
// top level of the line sensor proportional steering block
//
// takes one left-adjusted conversion per request from a rotating scan of four
// sensors (left, middle, right, front) and answers every request with one
// response carrying both motor pwm compare values, a steering flag, the
// channel the request was stored to and the latest front reading. the top
// SAMPLE_BITS bits of the conversion are the reading; line sensors are kept
// inverted (full scale minus reading), the front sensor is kept raw. once a
// line sensor is above line_threshold, the motor on the brighter side has its
// compare lowered by ceil(steer_gain * |left - right| / 256), clamped at zero.
// throughput is one request per clock while rsp_stall is low. a request
// stores its reading into the sensor registers, then its response goes
// through the steering multiply and clamp into the output register. the
// output register and the store stage each hold one request, so a new
// request is taken while a finished response waits, and back-pressure on
// the response side only reaches req_stall once both are full. valid flags,
// scan counter and sensor registers clear on reset, payload registers do
// not. csr map (32-bit apb-style, pready tied high): 0x0 line_threshold,
// 0x4 steer_gain, 0x8 base_compare; paddr[1:0] is ignored and writes to 0xc
// are dropped. program the registers only while no request is in flight.
module line_sensor_proportional_steering #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,

   // conversion requests
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lsps_pkg::CONV_W-1:0]           req_conv_high,
   input  logic [lsps_pkg::CONV_W-1:0]           req_conv_low,

   // steering responses
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lsps_pkg::COMPARE_W-1:0]        rsp_compare_a,
   output logic [lsps_pkg::COMPARE_W-1:0]        rsp_compare_b,
   output logic                                  rsp_steering_on,
   output logic [lsps_pkg::CHAN_W-1:0]           rsp_stored_channel,
   output logic [lsps_pkg::FRONT_W-1:0]          rsp_front_level,

   // configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [lsps_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [lsps_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [lsps_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int WORD_W = 2 * lsps_pkg::CONV_W;

   lsps_pkg::csr_regs_type      regs;
   lsps_pkg::steer_result_type  steer_res;

   // handshake
   logic out_advance;
   logic store_advance;
   logic req_accept;

   // store stage: sensor registers plus scan counter
   logic                          store_valid_ff, store_valid_in;
   logic [lsps_pkg::CHAN_W-1:0]   store_chan_ff, store_chan_in;
   logic [lsps_pkg::CHAN_W-1:0]   scan_chan_ff, scan_chan_in;
   logic [SAMPLE_BITS-1:0]        left_ff, left_in;
   logic [SAMPLE_BITS-1:0]        middle_ff, middle_in;
   logic [SAMPLE_BITS-1:0]        right_ff, right_in;
   logic [SAMPLE_BITS-1:0]        front_ff, front_in;

   logic [WORD_W-1:0]             conv_word;
   logic [SAMPLE_BITS-1:0]        raw_reading;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   lsps_pkg::steer_result_type    rsp_res_ff, rsp_res_in;
   logic [lsps_pkg::CHAN_W-1:0]   rsp_chan_ff, rsp_chan_in;
   logic [lsps_pkg::FRONT_W-1:0]  rsp_front_ff, rsp_front_in;

   lsps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .regs    (regs)
   );

   // output slot frees when empty or being taken; store slot frees when empty
   // or moving on into the output slot
   assign out_advance   = !rsp_valid_ff || !rsp_stall;
   assign store_advance = !store_valid_ff || out_advance;
   assign req_stall     = !store_advance;
   assign req_accept    = req_valid && store_advance;

   // top bits of the left-adjusted conversion
   assign conv_word   = {req_conv_high, req_conv_low};
   assign raw_reading = conv_word[WORD_W-1 -: SAMPLE_BITS];

   always_comb begin
      store_valid_in = store_advance ? req_valid : store_valid_ff;
      store_chan_in  = store_chan_ff;
      scan_chan_in   = scan_chan_ff;
      left_in        = left_ff;
      middle_in      = middle_ff;
      right_in       = right_ff;
      front_in       = front_ff;
      if (req_accept) begin
         store_chan_in = scan_chan_ff;
         scan_chan_in  = scan_chan_ff + lsps_pkg::CHAN_W'(1);
         // line sensors stored inverted, so a dark line reads high
         unique case (scan_chan_ff)
            lsps_pkg::CH_LEFT:   left_in   = ~raw_reading;
            lsps_pkg::CH_MIDDLE: middle_in = ~raw_reading;
            lsps_pkg::CH_RIGHT:  right_in  = ~raw_reading;
            lsps_pkg::CH_FRONT:  front_in  = raw_reading;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_valid_ff <= 1'b0;
         scan_chan_ff   <= lsps_pkg::CH_LEFT;
         left_ff        <= '0;
         middle_ff      <= '0;
         right_ff       <= '0;
         front_ff       <= '0;
      end else begin
         store_valid_ff <= store_valid_in;
         scan_chan_ff   <= scan_chan_in;
         left_ff        <= left_in;
         middle_ff      <= middle_in;
         right_ff       <= right_in;
         front_ff       <= front_in;
      end
      store_chan_ff <= store_chan_in;
   end

   // steering math works on the sensor registers as left by the stored request
   lsps_steer #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_steer (
      .left_level   (left_ff),
      .middle_level (middle_ff),
      .right_level  (right_ff),
      .regs         (regs),
      .result       (steer_res)
   );

   always_comb begin
      rsp_valid_in = out_advance ? store_valid_ff : rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_front_in = rsp_front_ff;
      if (out_advance && store_valid_ff) begin
         rsp_res_in   = steer_res;
         rsp_chan_in  = store_chan_ff;
         // front level shows the low ten bits of the reading
         rsp_front_in = lsps_pkg::FRONT_W'(front_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff   <= rsp_res_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_front_ff <= rsp_front_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_compare_a      = rsp_res_ff.compare_a;
   assign rsp_compare_b      = rsp_res_ff.compare_b;
   assign rsp_steering_on    = rsp_res_ff.steering_on;
   assign rsp_stored_channel = rsp_chan_ff;
   assign rsp_front_level    = rsp_front_ff;

endmodule

[hw/rtl/lsps_checker.sv]
// port-level checks for the steering block, bound to the top level
`include "line_sensor_proportional_steering_defines.svh"

module lsps_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [lsps_pkg::COMPARE_W-1:0]        rsp_compare_a,
   input logic [lsps_pkg::COMPARE_W-1:0]        rsp_compare_b,
   input logic                                  rsp_steering_on,
   input logic [lsps_pkg::CHAN_W-1:0]           rsp_stored_channel,
   input logic [lsps_pkg::FRONT_W-1:0]          rsp_front_level
);

   localparam int PAYLOAD_W = 2 * lsps_pkg::COMPARE_W + 1 + lsps_pkg::CHAN_W
                              + lsps_pkg::FRONT_W;

   logic                          req_take;
   logic                          rsp_take;
   logic                          rsp_straight;
   logic                          rsp_held;
   logic [PAYLOAD_W-1:0]          rsp_payload;
   logic [lsps_pkg::CHAN_W-1:0]   exp_chan_ff, exp_chan_in;
   logic [1:0]                    inflight_ff, inflight_in;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // response views used by the checks below
   assign rsp_straight = rsp_valid && !rsp_steering_on;
   assign rsp_held     = rsp_valid && rsp_stall;
   assign rsp_payload  = {rsp_compare_a, rsp_compare_b, rsp_steering_on,
                          rsp_stored_channel, rsp_front_level};

   // expected channel of the next response, and requests not yet answered
   assign exp_chan_in = rsp_take ? exp_chan_ff + lsps_pkg::CHAN_W'(1) : exp_chan_ff;
   assign inflight_in = inflight_ff + 2'(req_take) - 2'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_chan_ff <= lsps_pkg::CH_LEFT;
         inflight_ff <= '0;
      end else begin
         exp_chan_ff <= exp_chan_in;
         inflight_ff <= inflight_in;
      end
   end

   `LSPS_ASSERT_NOW(a_chan_order, clock, reset, rsp_valid, rsp_stored_channel == exp_chan_ff)
   `LSPS_ASSERT_NOW(a_inflight_bound, clock, reset, 1'b1, inflight_ff != 2'd3)
   `LSPS_ASSERT_NOW(a_straight_equal, clock, reset, rsp_straight, rsp_compare_a == rsp_compare_b)
   `LSPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

endmodule

bind line_sensor_proportional_steering lsps_checker u_lsps_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_compare_a      (rsp_compare_a),
   .rsp_compare_b      (rsp_compare_b),
   .rsp_steering_on    (rsp_steering_on),
   .rsp_stored_channel (rsp_stored_channel),
   .rsp_front_level    (rsp_front_level)
);
